>>> hdl/sls_pkg.sv
package sls_pkg;

  localparam int NUM_LINKS  = 4;
  localparam int LINK_IDX_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

  localparam int BASE_SCORE = 10000;
  localparam int CWND_DIV   = 100;
  localparam int DELAY_DIV  = 500;
  localparam int PENALTY    = 200;
  localparam logic [15:0] FAIL_MAX = 16'hFFFF;

  // reciprocals for exact truncating division of 32-bit values
  localparam logic [31:0] RECIP_CWND  = 32'h51EB_851F; // 2^37 / 100, rounded up
  localparam logic [31:0] RECIP_DELAY = 32'h1062_4DD3; // 2^37 / 500, rounded up
  localparam int          RECIP_SHIFT = 37;

  // signed metric term, raw signed score, clamped score
  localparam int TERM_W  = 28;
  localparam int SUM_W   = 29;
  localparam int SCORE_W = 26;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_PICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OC_SENT        = 2'd0,
    OC_WOULD_BLOCK = 2'd1,
    OC_CLOSED      = 2'd2,
    OC_PARTIAL     = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } core_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  link;
    logic        link_up;
    logic        in_backoff;
    logic [31:0] cwnd_bytes;
    logic [31:0] rtt_us;
    logic [31:0] inflight_bytes;
    logic [15:0] timeout_count;
    logic [1:0]  outcome;
  } item_t;

  typedef struct packed {
    logic [3:0]         chosen_link;
    logic [SCORE_W-1:0] link_score;
    logic               fallback;
    logic               no_link;
    logic               last;
  } res_t;

endpackage

>>> hdl/sls_if.sv
interface sls_item_if;
  import sls_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sls_res_if;
  import sls_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sls_front.sv
module sls_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  sls_item_if.sink   in_if,
  sls_item_if.source q_if
);
  import sls_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       useful, push, pop;

  // classify: drop unused kinds and out-of-range links
  always_comb begin
    case (in_if.data.kind)
      KIND_PICK:   useful = 1'b1;
      KIND_UPDATE,
      KIND_REPORT: useful = ({1'b0, in_if.data.link} < 5'(NUM_LINKS));
      default:     useful = 1'b0;
    endcase
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready && useful;
  assign q_if.valid  = (cnt_q != 2'd0);
  assign q_if.data   = mem_q[rd_q];
  assign pop         = q_if.valid && q_if.ready;

  // two-entry queue toward the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_if.data;
  end

endmodule

>>> hdl/sls_cdiv.sv
module sls_cdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] cwnd_i,
  input  logic [31:0] rtt_i,
  input  logic [31:0] infl_i,
  output logic        done_o,
  output logic [25:0] q_cwnd_o,
  output logic [23:0] q_rtt_o,
  output logic [23:0] q_infl_o
);
  import sls_pkg::*;

  logic [31:0] a_q, b_q, c_q;
  logic [25:0] qa_q;
  logic [23:0] qb_q, qc_q;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] op, recip;
  logic [63:0] prod;

  // one operand per step through the shared reciprocal multiplier
  always_comb begin
    case (step_q)
      2'd0: begin
        op    = a_q;
        recip = RECIP_CWND;
      end
      2'd1: begin
        op    = b_q;
        recip = RECIP_DELAY;
      end
      default: begin
        op    = c_q;
        recip = RECIP_DELAY;
      end
    endcase
  end

  assign prod = {32'b0, op} * {32'b0, recip};

  // control: three multiply steps per start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and quotients
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= cwnd_i;
      b_q <= rtt_i;
      c_q <= infl_i;
    end else if (busy_q) begin
      case (step_q)
        2'd0:    qa_q <= prod[RECIP_SHIFT+25:RECIP_SHIFT];
        2'd1:    qb_q <= prod[RECIP_SHIFT+23:RECIP_SHIFT];
        default: qc_q <= prod[RECIP_SHIFT+23:RECIP_SHIFT];
      endcase
    end
  end

  assign done_o   = done_q;
  assign q_cwnd_o = qa_q;
  assign q_rtt_o  = qb_q;
  assign q_infl_o = qc_q;

endmodule

>>> hdl/sls_core.sv
module sls_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  sls_item_if.sink    cmd_if,
  sls_res_if.source   res_if
);
  import sls_pkg::*;

  localparam int N = NUM_LINKS;
  localparam int IW = LINK_IDX_W;

  core_state_e state_q, state_d;

  logic                     up_q   [N];
  logic                     bo_q   [N];
  logic signed [TERM_W-1:0] term_q [N];
  logic [15:0]              fail_q [N];
  logic [N-1:0]             emitted_q;
  logic [IW-1:0]            rot_q, j_q, best_idx_q, upd_link_q;
  logic                     found_q, upd_up_q, upd_bo_q;
  logic [15:0]              upd_to_q;
  logic [SCORE_W-1:0]       best_q;
  res_t                     res_q, res_d;
  logic                     out_vld_q;

  logic [N-1:0]             elig, cand, best_mask, remain;
  logic                     any_elig, out_free, load, accept, div_done, start_div;
  logic [IW:0]              xsum;
  logic [IW-1:0]            x;
  logic [23:0]              pen;
  logic signed [SUM_W-1:0]  raw;
  logic [SCORE_W-1:0]       sc;
  logic [25:0]              q_cwnd;
  logic [23:0]              q_rtt, q_infl;
  logic signed [TERM_W-1:0] new_term;
  logic [IW-1:0]            cmd_idx;

  sls_cdiv u_cdiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_div),
    .cwnd_i   (cmd_if.data.cwnd_bytes),
    .rtt_i    (cmd_if.data.rtt_us),
    .infl_i   (cmd_if.data.inflight_bytes),
    .done_o   (div_done),
    .q_cwnd_o (q_cwnd),
    .q_rtt_o  (q_rtt),
    .q_infl_o (q_infl)
  );

  // candidate masks
  always_comb begin
    for (int i = 0; i < N; i++) begin
      elig[i] = up_q[i] && !bo_q[i];
    end
    any_elig = |elig;
    for (int i = 0; i < N; i++) begin
      cand[i]      = any_elig ? elig[i] : up_q[i];
      best_mask[i] = (IW'(i) == best_idx_q);
    end
    remain = cand & ~emitted_q & ~best_mask;
  end

  // link under scan in rotation order, and its score
  assign xsum = {1'b0, rot_q} + {1'b0, j_q};
  assign x    = (xsum >= (IW+1)'(N)) ? IW'(xsum - (IW+1)'(N)) : xsum[IW-1:0];
  assign pen  = 24'(fail_q[x]) * 24'(PENALTY);
  assign raw  = SUM_W'(BASE_SCORE) + SUM_W'(term_q[x]) - $signed({5'b0, pen});
  assign sc   = (!any_elig || raw[SUM_W-1]) ? '0 : SCORE_W'(raw);

  // metric term from the divider quotients
  assign new_term = $signed({2'b0, q_cwnd}) - $signed({4'b0, q_rtt})
                  - $signed({4'b0, q_infl})
                  - $signed({4'b0, 24'(upd_to_q) * 24'(PENALTY)});

  assign cmd_idx  = cmd_if.data.link[IW-1:0];
  assign out_free = !out_vld_q || res_if.ready;
  assign cmd_if.ready = (state_q == ST_IDLE);
  assign accept    = cmd_if.valid && cmd_if.ready;
  assign start_div = accept && (cmd_if.data.kind == KIND_UPDATE);

  // next state and result
  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    res_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_if.data.kind)
            KIND_UPDATE: state_d = ST_DIV;
            KIND_PICK:   state_d = ST_SCAN;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: if (div_done) state_d = ST_IDLE;
      ST_SCAN: if (j_q == IW'(N - 1)) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (found_q) begin
            res_d.chosen_link = 4'(best_idx_q);
            res_d.link_score  = best_q;
            res_d.fallback    = !any_elig;
            res_d.last        = (remain == '0);
          end else begin
            res_d.no_link = 1'b1;
            res_d.last    = 1'b1;
          end
          state_d = res_d.last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // link state, scan bookkeeping, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        up_q[i]   <= 1'b0;
        bo_q[i]   <= 1'b0;
        term_q[i] <= '0;
        fail_q[i] <= '0;
      end
      emitted_q <= '0;
      rot_q     <= '0;
      j_q       <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept && cmd_if.data.kind == KIND_REPORT) begin
        case (outcome_e'(cmd_if.data.outcome))
          OC_SENT: fail_q[cmd_idx] <= '0;
          OC_WOULD_BLOCK: begin
            if (fail_q[cmd_idx] != FAIL_MAX) fail_q[cmd_idx] <= fail_q[cmd_idx] + 16'd1;
          end
          OC_CLOSED, OC_PARTIAL: begin
            if (fail_q[cmd_idx] != FAIL_MAX) fail_q[cmd_idx] <= fail_q[cmd_idx] + 16'd1;
            up_q[cmd_idx] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (accept && cmd_if.data.kind == KIND_PICK) begin
        emitted_q <= '0;
        j_q       <= '0;
        found_q   <= 1'b0;
      end
      if (state_q == ST_DIV && div_done) begin
        up_q[upd_link_q]   <= upd_up_q;
        bo_q[upd_link_q]   <= upd_bo_q;
        term_q[upd_link_q] <= new_term;
      end
      if (state_q == ST_SCAN) begin
        j_q <= (j_q == IW'(N - 1)) ? '0 : j_q + IW'(1);
        if (cand[x] && !emitted_q[x] && (!found_q || sc > best_q)) begin
          found_q <= 1'b1;
        end
      end
      if (load) begin
        emitted_q <= emitted_q | best_mask;
        found_q   <= 1'b0;
        j_q       <= '0;
        if (res_d.last) rot_q <= (rot_q == IW'(N - 1)) ? '0 : rot_q + IW'(1);
      end
      if (load)              out_vld_q <= 1'b1;
      else if (res_if.ready) out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_div) begin
      upd_link_q <= cmd_idx;
      upd_up_q   <= cmd_if.data.link_up;
      upd_bo_q   <= cmd_if.data.in_backoff;
      upd_to_q   <= cmd_if.data.timeout_count;
    end
    if (state_q == ST_SCAN && cand[x] && !emitted_q[x] && (!found_q || sc > best_q)) begin
      best_idx_q <= x;
      best_q     <= sc;
    end
    if (load) res_q <= res_d;
  end

  assign res_if.valid = out_vld_q;
  assign res_if.data  = res_q;

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside update");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && found_q) |-> !emitted_q[best_idx_q])
    else $error("link offered twice in one pick");

  a_rot_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_d.last) |=> (rot_q != $past(rot_q)) || (N == 1))
    else $error("rotation did not advance after pick");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_vld_q || res_if.ready))
    else $error("result overwritten before transfer");

endmodule

>>> hdl/scored_link_selector_unit.sv
// Scored link selector.
// in_if carries items: metric updates, send outcome reports and pick
// requests. Updates and reports produce no result; items of the unused
// kind, and updates or reports naming a link past the link count, are
// dropped at the front. out_if carries the ranked links of a pick, one
// transfer per link, the final one with last set. With no connected link
// a single transfer with no_link set is given.
// A two-entry queue sits between the front and the execution core, so
// input transfers keep flowing while the core is busy until the queue fills.
// In the core a report is applied when it is accepted; an update waits
// for the shared reciprocal multiplier that turns the window, rtt and
// inflight metrics into the metric term, one per cycle; a pick is
// accepted, then each result takes a scan over every link in rotation
// order and an emit step.
// A stalled receiver holds the output register, the core waits in its emit
// step, and once the queue is full in_if.ready drops.
// Reset marks all links down, clears metrics, failure counts and the
// rotation start, and empties the queue.
module scored_link_selector_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sls_item_if.sink  in_if,
  sls_res_if.source out_if
);
  import sls_pkg::*;

  sls_item_if q_if ();

  sls_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .q_if   (q_if.source)
  );

  sls_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_if (q_if.sink),
    .res_if (out_if)
  );

endmodule

>>> sim/scored_link_selector_unit_test.sv
`timescale 1ns / 1ps

module scored_link_selector_unit_test;
  import sls_pkg::*;

  localparam int IDLE_DRAIN = 200;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sls_item_if in_if ();
  sls_res_if out_if ();

  scored_link_selector_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // link ranking predictor and queue of pending offers
  class link_rank_board;
    logic        up_q [NUM_LINKS];
    logic        boff_q [NUM_LINKS];
    logic [31:0] cwnd_q [NUM_LINKS];
    logic [31:0] rtt_q [NUM_LINKS];
    logic [31:0] infl_q [NUM_LINKS];
    logic [15:0] tmo_q [NUM_LINKS];
    logic [15:0] fail_q [NUM_LINKS];
    int          rot_start;
    res_t        offers_q [$];
    int          errors;
    int          picks;
    int          results;

    function new();
      for (int i = 0; i < NUM_LINKS; i++) begin
        up_q[i] = 0; boff_q[i] = 0; cwnd_q[i] = 0; rtt_q[i] = 0;
        infl_q[i] = 0; tmo_q[i] = 0; fail_q[i] = 0;
      end
      rot_start = 0;
      errors = 0;
      picks = 0;
      results = 0;
    endfunction

    function longint rate(int i);
      longint s;
      if (!up_q[i] || boff_q[i]) return -1;
      s = BASE_SCORE + longint'(cwnd_q[i] / CWND_DIV) - longint'(rtt_q[i] / DELAY_DIV)
          - longint'(infl_q[i] / DELAY_DIV) - longint'(tmo_q[i]) * PENALTY
          - longint'(fail_q[i]) * PENALTY;
      return (s > 0) ? s : 0;
    endfunction

    function void note_item(item_t it);
      longint sc [NUM_LINKS];
      int     ord [NUM_LINKS];
      int     sel [$];
      longint best;
      bit     same;
      int     v, j;
      res_t   r;
      if (it.kind == KIND_UPDATE) begin
        if (it.link >= NUM_LINKS) return;
        up_q[it.link] = it.link_up; boff_q[it.link] = it.in_backoff;
        cwnd_q[it.link] = it.cwnd_bytes; rtt_q[it.link] = it.rtt_us;
        infl_q[it.link] = it.inflight_bytes; tmo_q[it.link] = it.timeout_count;
        return;
      end
      if (it.kind == KIND_REPORT) begin
        if (it.link >= NUM_LINKS) return;
        if (it.outcome == OC_SENT) fail_q[it.link] = 0;
        else begin
          if (fail_q[it.link] != FAIL_MAX) fail_q[it.link]++;
          if (it.outcome == OC_CLOSED || it.outcome == OC_PARTIAL) up_q[it.link] = 0;
        end
        return;
      end
      if (it.kind != KIND_PICK) return;
      picks++;
      best = -1;
      same = 1;
      for (int i = 0; i < NUM_LINKS; i++) begin
        sc[i] = rate(i);
        if (sc[i] != sc[0]) same = 0;
        if (sc[i] > best) best = sc[i];
      end
      for (int i = 0; i < NUM_LINKS; i++) ord[i] = (rot_start + i) % NUM_LINKS;
      rot_start = (rot_start + 1) % NUM_LINKS;
      // stable descending sort only when scores differ
      if (!same) begin
        for (int i = 1; i < NUM_LINKS; i++) begin
          v = ord[i];
          j = i;
          while (j > 0 && sc[ord[j-1]] < sc[v]) begin
            ord[j] = ord[j-1];
            j--;
          end
          ord[j] = v;
        end
      end
      for (int i = 0; i < NUM_LINKS; i++)
        if ((best >= 0) ? (sc[ord[i]] >= 0) : up_q[ord[i]]) sel.push_back(ord[i]);
      if (sel.size() == 0) begin
        r = '0;
        r.no_link = 1;
        r.last = 1;
        offers_q.push_back(r);
        return;
      end
      foreach (sel[k]) begin
        r = '0;
        r.chosen_link = 4'(sel[k]);
        r.link_score = (best >= 0) ? sc[sel[k]][SCORE_W-1:0] : '0;
        r.fallback = (best < 0);
        r.last = (k == sel.size() - 1);
        offers_q.push_back(r);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      results++;
      if (offers_q.size() == 0) begin
        $error("unexpected result transfer: link %0d", got.chosen_link);
        errors++;
        return;
      end
      want = offers_q.pop_front();
      if (got.chosen_link !== want.chosen_link) begin
        $error("chosen_link: expected %0d, got %0d", want.chosen_link, got.chosen_link);
        errors++;
      end
      if (got.link_score !== want.link_score) begin
        $error("link_score: expected %0d, got %0d", want.link_score, got.link_score);
        errors++;
      end
      if (got.fallback !== want.fallback) begin
        $error("fallback: expected %0b, got %0b", want.fallback, got.fallback);
        errors++;
      end
      if (got.no_link !== want.no_link) begin
        $error("no_link: expected %0b, got %0b", want.no_link, got.no_link);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  link_rank_board board = new();
  int  idle_cycles = 0;
  bit  hold_off = 0;
  bit  stim_done = 0;
  int  sent_items = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // offer one item and wait for its transfer
  task automatic send_item(item_t it);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_item(it);
    sent_items++;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 2000000);
      default: return $urandom_range(0, 100000);
    endcase
  endfunction

  function automatic item_t mk_update(int lnk, bit up, bit bo, logic [31:0] cw,
                                      logic [31:0] rt, logic [31:0] inf, logic [15:0] tm);
    item_t it;
    it = '0;
    it.kind = KIND_UPDATE; it.link = 4'(lnk); it.link_up = up; it.in_backoff = bo;
    it.cwnd_bytes = cw; it.rtt_us = rt; it.inflight_bytes = inf; it.timeout_count = tm;
    it.outcome = 2'($urandom());
    return it;
  endfunction

  function automatic item_t mk_report(int lnk, logic [1:0] oc);
    item_t        it;
    logic [127:0] fill;
    fill = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = fill[$bits(item_t)-1:0];
    it.cwnd_bytes = $urandom();
    it.kind = KIND_REPORT; it.link = 4'(lnk); it.outcome = oc;
    return it;
  endfunction

  function automatic item_t mk_pick();
    item_t it;
    it = '0;
    it.rtt_us = $urandom();
    it.inflight_bytes = $urandom();
    it.kind = KIND_PICK; it.link = 4'($urandom()); it.link_up = 1'($urandom());
    it.in_backoff = 1'($urandom());
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t        it;
    int           r;
    logic [127:0] fill;
    r = $urandom_range(0, 99);
    if (r < 35)
      it = mk_update($urandom_range(0, NUM_LINKS - 1), $urandom_range(0, 5) != 0,
                     $urandom_range(0, 5) == 0, pick32(), pick32(), pick32(),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20)));
    else if (r < 55) it = mk_report($urandom_range(0, NUM_LINKS - 1), 2'($urandom()));
    else if (r < 92) it = mk_pick();
    else begin
      // noise: bad link index or unused kind
      fill = {$urandom(), $urandom(), $urandom(), $urandom()};
      it = fill[$bits(item_t)-1:0];
      if (r < 96) it.link = 4'($urandom_range(NUM_LINKS, 15));
      else it.kind = KIND_NONE;
    end
    return it;
  endfunction

  // stimulus
  initial begin
    item_t it;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty pick, extremes, outcomes, fallback, ties
    send_item(mk_pick());
    send_item(mk_update(0, 1, 0, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0));
    send_item(mk_update(1, 1, 0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk_update(2, 1, 1, 32'd5000, 32'd1000, 32'd1000, 16'd1));
    send_item(mk_update(3, 1, 0, 32'd0, 32'd0, 32'd0, 16'd0));
    send_item(mk_pick());
    send_item(mk_report(3, OC_WOULD_BLOCK));
    send_item(mk_report(3, OC_WOULD_BLOCK));
    send_item(mk_pick());
    send_item(mk_report(3, OC_SENT));
    send_item(mk_report(0, OC_CLOSED));
    send_item(mk_report(3, OC_PARTIAL));
    send_item(mk_pick());
    send_item(mk_update(1, 1, 1, 32'd0, 32'd0, 32'd0, 16'd0));
    send_item(mk_pick());
    it = mk_update(15, 1, 0, 32'd1, 32'd1, 32'd1, 16'd1);
    send_item(it);
    it = mk_report(12, OC_CLOSED);
    send_item(it);
    it = mk_pick();
    it.kind = KIND_NONE;
    send_item(it);
    for (int i = 0; i < NUM_LINKS; i++)
      send_item(mk_update(i, 1, 0, 32'd100, 32'd0, 32'd0, 16'd0));
    send_item(mk_pick());
    send_item(mk_pick());
    // raise the failure count of link 2 with would-block reports
    send_item(mk_update(2, 1, 0, 32'd0, 32'd0, 32'd0, 16'd0));
    for (int k = 0; k < 3; k++) send_item(mk_report(2, OC_WOULD_BLOCK));
    send_item(mk_pick());
    // random part
    while (sent_items < 480) send_item(rand_item());
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (board.picks >= 40 && !hold_off) begin
        hold_off = 1;
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) board.check_result(out_if.data);
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (board.offers_q.size() != 0 && idle_cycles < STALL_LIMIT) @(posedge clk_i);
    if (board.offers_q.size() == 0) repeat (IDLE_DRAIN) @(posedge clk_i);
    $display("covered %0d items, %0d picks, %0d result transfers checked",
             sent_items, board.picks, board.results);
    if (board.offers_q.size() != 0) begin
      $error("%0d expected results never arrived", board.offers_q.size());
      board.errors++;
    end
    if (board.errors == 0) $display("scored_link_selector_unit_test: PASS");
    else $display("scored_link_selector_unit_test: FAIL");
    $finish;
  end

  // stall watchdog
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("scored_link_selector_unit_test: FAIL");
    $finish;
  end

endmodule

>>> files.f
hdl/sls_pkg.sv
hdl/sls_if.sv
hdl/sls_front.sv
hdl/sls_cdiv.sv
hdl/sls_core.sv
hdl/scored_link_selector_unit.sv
sim/scored_link_selector_unit_test.sv
